// ===== rtl/dcf_pkg.sv =====
// shared types and constants for the dual channel fir filter
`default_nettype none

package dcf_pkg;

    localparam int OP_W      = 2;
    localparam int FRAC_BITS = 15;
    localparam int OUT_WIDTH = 24;
    localparam int CFG_IDX_W = 1;

    localparam logic [OP_W-1:0] OP_COEF   = 2'd0;
    localparam logic [OP_W-1:0] OP_SAMPLE = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_TAP_COUNT  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_INPUT_MODE = 1'b1;

    typedef struct packed {
        logic clear_step;
        logic hist_write;
        logic mac_step;
        logic finish;
    } dcf_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic mac_last;
        logic pipe_busy;
        logic out_free;
    } dcf_stat_t;

endpackage

`default_nettype wire

// ===== rtl/dcf_item_if.sv =====
// input channel carrying coefficient, sample and clear beats
`default_nettype none

interface dcf_item_if #(
    parameter int IDX_W        = 8,
    parameter int SAMPLE_WIDTH = 16,
    parameter int COEF_WIDTH   = 18
);
    logic                          valid;
    logic                          ready;
    logic [dcf_pkg::OP_W-1:0]      operation;
    logic [IDX_W-1:0]              tap_index;
    logic signed [COEF_WIDTH-1:0]  coef_i;
    logic signed [COEF_WIDTH-1:0]  coef_q;
    logic signed [SAMPLE_WIDTH-1:0] sample_i;
    logic signed [SAMPLE_WIDTH-1:0] sample_q;
    logic                          last_in;

    modport source (
        output valid, operation, tap_index, coef_i, coef_q, sample_i, sample_q, last_in,
        input  ready
    );

    modport sink (
        input  valid, operation, tap_index, coef_i, coef_q, sample_i, sample_q, last_in,
        output ready
    );

    modport monitor (
        input valid, ready, operation, tap_index, coef_i, coef_q, sample_i, sample_q, last_in
    );
endinterface

`default_nettype wire

// ===== rtl/dcf_result_if.sv =====
// output channel carrying filtered i/q results
`default_nettype none

interface dcf_result_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [dcf_pkg::OUT_WIDTH-1:0] out_i;
    logic signed [dcf_pkg::OUT_WIDTH-1:0] out_q;
    logic                                 clipped;
    logic                                 last_out;

    modport source (
        output valid, out_i, out_q, clipped, last_out,
        input  ready
    );

    modport sink (
        input  valid, out_i, out_q, clipped, last_out,
        output ready
    );
endinterface

`default_nettype wire

// ===== rtl/dual_channel_fir_filter.sv =====
// sample beat: accepted in IDLE, then LOAD (history write), MAC (tap loop), DRAIN,
// DONE (result register loads once the output is free); the next beat waits for IDLE
// the tap loop runs one multiply-accumulate per tap per channel on the memory read port
// coefficient write: taken in IDLE; clear: zeroes all MAX_TAPS entries of both histories
// reset: control state clears and a history sweep runs before the first beat
`default_nettype none

module dual_channel_fir_filter #(
    parameter int MAX_TAPS     = 256,
    parameter int SAMPLE_WIDTH = 16,
    parameter int COEF_WIDTH   = 18
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    dcf_item_if.sink                             item,
    dcf_result_if.source                         result,
    input  wire logic                            cfg_write_en,
    input  wire logic [dcf_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [$clog2(MAX_TAPS):0]       cfg_data
);

    localparam int TC_W = $clog2(MAX_TAPS) + 1;

    logic [TC_W-1:0]    tap_count_reg;
    logic               input_mode_reg;
    logic               ready;
    dcf_pkg::dcf_cmd_t  cmd;
    dcf_pkg::dcf_stat_t stat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tap_count_reg  <= TC_W'(1);
            input_mode_reg <= 1'b0;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                dcf_pkg::CFG_TAP_COUNT:  tap_count_reg  <= cfg_data;
                dcf_pkg::CFG_INPUT_MODE: input_mode_reg <= cfg_data[0];
                default:                 tap_count_reg  <= tap_count_reg;
            endcase
        end
    end

    assign item.ready = ready;

    dcf_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .item  (item),
        .ready (ready),
        .cmd   (cmd),
        .stat  (stat)
    );

    dcf_datapath #(
        .MAX_TAPS     (MAX_TAPS),
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .COEF_WIDTH   (COEF_WIDTH)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .tap_count  (tap_count_reg),
        .input_mode (input_mode_reg),
        .item       (item),
        .result     (result),
        .cmd        (cmd),
        .stat       (stat)
    );

endmodule

`default_nettype wire

// ===== rtl/dcf_ctrl.sv =====
// controller state machine sequencing clear sweeps and tap loops
`default_nettype none

module dcf_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    dcf_item_if.sink               item,
    output logic                   ready,
    output dcf_pkg::dcf_cmd_t      cmd,
    input  wire dcf_pkg::dcf_stat_t stat
);

    localparam logic [2:0] S_SWEEP = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_LOAD  = 3'd2;
    localparam logic [2:0] S_MAC   = 3'd3;
    localparam logic [2:0] S_DRAIN = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        ready      = 1'b0;
        case (state_reg)
            S_SWEEP:
            begin
                cmd.clear_step = 1'b1;
                if (stat.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                ready = 1'b1;
                if (item.valid)
                begin
                    case (item.operation)
                        dcf_pkg::OP_SAMPLE: state_next = S_LOAD;
                        dcf_pkg::OP_CLEAR:  state_next = S_SWEEP;
                        default:            state_next = S_IDLE;
                    endcase
                end
            end
            S_LOAD:
            begin
                cmd.hist_write = 1'b1;
                state_next     = S_MAC;
            end
            S_MAC:
            begin
                cmd.mac_step = 1'b1;
                if (stat.mac_last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                if (!stat.pipe_busy)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                cmd.finish = 1'b1;
                if (stat.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_SWEEP;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/dcf_mac.sv =====
// one channel: history and coefficient memories, multiply-accumulate, rounding
`default_nettype none

module dcf_mac #(
    parameter int MAX_TAPS     = 256,
    parameter int SAMPLE_WIDTH = 16,
    parameter int COEF_WIDTH   = 18
) (
    input  wire logic                               clk,
    input  wire logic                               coef_we,
    input  wire logic [$clog2(MAX_TAPS)-1:0]        coef_waddr,
    input  wire logic signed [COEF_WIDTH-1:0]       coef_wdata,
    input  wire logic                               hist_we,
    input  wire logic [$clog2(MAX_TAPS)-1:0]        hist_waddr,
    input  wire logic signed [SAMPLE_WIDTH-1:0]     hist_wdata,
    input  wire logic                               rd_en,
    input  wire logic [$clog2(MAX_TAPS)-1:0]        coef_raddr,
    input  wire logic [$clog2(MAX_TAPS)-1:0]        hist_raddr,
    input  wire logic                               mul_en,
    input  wire logic                               acc_clr,
    input  wire logic                               acc_en,
    output logic signed [dcf_pkg::OUT_WIDTH-1:0]    y,
    output logic                                    sat
);

    localparam int PROD_W = SAMPLE_WIDTH + COEF_WIDTH;
    localparam int ACC_W  = PROD_W + $clog2(MAX_TAPS);
    localparam int EXT_W  = (ACC_W + 1 > dcf_pkg::FRAC_BITS + dcf_pkg::OUT_WIDTH + 1) ?
                            ACC_W + 1 : dcf_pkg::FRAC_BITS + dcf_pkg::OUT_WIDTH + 1;
    localparam int Q_W    = EXT_W - dcf_pkg::FRAC_BITS;
    localparam int PAD_W  = Q_W - dcf_pkg::OUT_WIDTH + 1;

    localparam logic signed [Q_W-1:0] Q_HI =
        {{PAD_W{1'b0}}, {(dcf_pkg::OUT_WIDTH-1){1'b1}}};
    localparam logic signed [Q_W-1:0] Q_LO =
        {{PAD_W{1'b1}}, {(dcf_pkg::OUT_WIDTH-1){1'b0}}};
    localparam logic signed [EXT_W-1:0] ROUND_C =
        EXT_W'(1) << (dcf_pkg::FRAC_BITS - 1);

    logic signed [COEF_WIDTH-1:0]   coef_mem [MAX_TAPS];
    logic signed [SAMPLE_WIDTH-1:0] hist_mem [MAX_TAPS];

    logic signed [COEF_WIDTH-1:0]   coef_rd_reg;
    logic signed [SAMPLE_WIDTH-1:0] hist_rd_reg;
    logic signed [PROD_W-1:0]       prod_reg;
    logic signed [ACC_W-1:0]        acc_reg;

    logic signed [EXT_W-1:0] acc_ext;
    logic signed [EXT_W-1:0] rounded;
    logic signed [Q_W-1:0]   quot;

    always_ff @(posedge clk)
    begin
        if (coef_we)
        begin
            coef_mem[coef_waddr] <= coef_wdata;
        end
        if (rd_en)
        begin
            coef_rd_reg <= coef_mem[coef_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (hist_we)
        begin
            hist_mem[hist_waddr] <= hist_wdata;
        end
        if (rd_en)
        begin
            hist_rd_reg <= hist_mem[hist_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (mul_en)
        begin
            prod_reg <= hist_rd_reg * coef_rd_reg;
        end
        if (acc_clr)
        begin
            acc_reg <= '0;
        end
        else if (acc_en)
        begin
            acc_reg <= acc_reg + ACC_W'(prod_reg);
        end
    end

    // round half up, floor shift, saturate
    always_comb
    begin
        acc_ext = EXT_W'(acc_reg);
        rounded = acc_ext + ROUND_C;
        quot    = Q_W'(rounded >>> dcf_pkg::FRAC_BITS);
        if (quot > Q_HI)
        begin
            sat = 1'b1;
            y   = Q_HI[dcf_pkg::OUT_WIDTH-1:0];
        end
        else if (quot < Q_LO)
        begin
            sat = 1'b1;
            y   = Q_LO[dcf_pkg::OUT_WIDTH-1:0];
        end
        else
        begin
            sat = 1'b0;
            y   = quot[dcf_pkg::OUT_WIDTH-1:0];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/dcf_datapath.sv =====
// datapath: beat capture, address counters, two channel units, result register
`default_nettype none

module dcf_datapath #(
    parameter int MAX_TAPS     = 256,
    parameter int SAMPLE_WIDTH = 16,
    parameter int COEF_WIDTH   = 18
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic [$clog2(MAX_TAPS):0]   tap_count,
    input  wire logic                        input_mode,
    dcf_item_if.sink                         item,
    dcf_result_if.source                     result,
    input  wire dcf_pkg::dcf_cmd_t           cmd,
    output dcf_pkg::dcf_stat_t               stat
);

    localparam int IDX_W = $clog2(MAX_TAPS);
    localparam int CNT_W = $clog2(MAX_TAPS + 1);
    localparam int TC_W  = $clog2(MAX_TAPS) + 1;

    logic accept;
    logic coef_we;
    logic out_free;

    logic signed [SAMPLE_WIDTH-1:0] sample_i_reg;
    logic signed [SAMPLE_WIDTH-1:0] sample_q_reg;
    logic                           last_reg;

    logic [IDX_W-1:0] wp_reg;
    logic [IDX_W-1:0] clr_addr_reg;
    logic [IDX_W-1:0] j_reg;
    logic [IDX_W-1:0] k_reg;
    logic [CNT_W-1:0] n_reg;
    logic             rd_vld_reg;
    logic             prod_vld_reg;
    logic             out_valid_reg;

    logic signed [dcf_pkg::OUT_WIDTH-1:0] out_i_reg;
    logic signed [dcf_pkg::OUT_WIDTH-1:0] out_q_reg;
    logic                                 clipped_reg;
    logic                                 last_out_reg;

    logic [CNT_W-1:0] n_eff;
    logic [IDX_W-1:0] n_last;
    logic [IDX_W-1:0] nreg_last;
    logic [IDX_W-1:0] pos;

    logic                           hist_we;
    logic [IDX_W-1:0]               hist_waddr;
    logic signed [SAMPLE_WIDTH-1:0] hist_wdata_i;
    logic signed [SAMPLE_WIDTH-1:0] hist_wdata_q;

    logic signed [dcf_pkg::OUT_WIDTH-1:0] y_i;
    logic signed [dcf_pkg::OUT_WIDTH-1:0] y_q;
    logic                                 sat_i;
    logic                                 sat_q;

    assign accept   = item.valid & item.ready;
    assign coef_we  = accept && (item.operation == dcf_pkg::OP_COEF) &&
                      ({1'b0, item.tap_index} < (IDX_W + 1)'(MAX_TAPS));
    assign out_free = !out_valid_reg || result.ready;

    // tap count clamped to 1..MAX_TAPS
    always_comb
    begin
        if (tap_count == '0)
        begin
            n_eff = CNT_W'(1);
        end
        else if (tap_count > TC_W'(MAX_TAPS))
        begin
            n_eff = CNT_W'(MAX_TAPS);
        end
        else
        begin
            n_eff = CNT_W'(tap_count);
        end
    end

    assign n_last    = IDX_W'(n_eff - CNT_W'(1));
    assign nreg_last = IDX_W'(n_reg - CNT_W'(1));
    assign pos       = (CNT_W'(wp_reg) >= n_eff) ? '0 : wp_reg;

    assign hist_we      = cmd.clear_step | cmd.hist_write;
    assign hist_waddr   = cmd.clear_step ? clr_addr_reg : pos;
    assign hist_wdata_i = cmd.clear_step ? '0 : sample_i_reg;
    assign hist_wdata_q = cmd.clear_step ? '0 : sample_q_reg;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sample_i_reg <= item.sample_i;
            sample_q_reg <= input_mode ? item.sample_i : item.sample_q;
            last_reg     <= item.last_in;
        end
        if (cmd.finish && out_free)
        begin
            out_i_reg    <= y_i;
            out_q_reg    <= y_q;
            clipped_reg  <= sat_i | sat_q;
            last_out_reg <= last_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg        <= '0;
            clr_addr_reg  <= '0;
            j_reg         <= '0;
            k_reg         <= '0;
            n_reg         <= CNT_W'(1);
            rd_vld_reg    <= 1'b0;
            prod_vld_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clear_step)
            begin
                clr_addr_reg <= (clr_addr_reg == IDX_W'(MAX_TAPS - 1)) ?
                                '0 : clr_addr_reg + IDX_W'(1);
                wp_reg       <= '0;
            end
            if (cmd.hist_write)
            begin
                n_reg  <= n_eff;
                j_reg  <= pos;
                k_reg  <= '0;
                wp_reg <= (pos == '0) ? n_last : pos - IDX_W'(1);
            end
            if (cmd.mac_step)
            begin
                j_reg <= (j_reg == nreg_last) ? '0 : j_reg + IDX_W'(1);
                k_reg <= k_reg + IDX_W'(1);
            end
            rd_vld_reg   <= cmd.mac_step;
            prod_vld_reg <= rd_vld_reg;
            if (cmd.finish && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    dcf_mac #(
        .MAX_TAPS     (MAX_TAPS),
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .COEF_WIDTH   (COEF_WIDTH)
    ) u_mac_i (
        .clk        (clk),
        .coef_we    (coef_we),
        .coef_waddr (item.tap_index),
        .coef_wdata (item.coef_i),
        .hist_we    (hist_we),
        .hist_waddr (hist_waddr),
        .hist_wdata (hist_wdata_i),
        .rd_en      (cmd.mac_step),
        .coef_raddr (k_reg),
        .hist_raddr (j_reg),
        .mul_en     (rd_vld_reg),
        .acc_clr    (cmd.hist_write),
        .acc_en     (prod_vld_reg),
        .y          (y_i),
        .sat        (sat_i)
    );

    dcf_mac #(
        .MAX_TAPS     (MAX_TAPS),
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .COEF_WIDTH   (COEF_WIDTH)
    ) u_mac_q (
        .clk        (clk),
        .coef_we    (coef_we),
        .coef_waddr (item.tap_index),
        .coef_wdata (item.coef_q),
        .hist_we    (hist_we),
        .hist_waddr (hist_waddr),
        .hist_wdata (hist_wdata_q),
        .rd_en      (cmd.mac_step),
        .coef_raddr (k_reg),
        .hist_raddr (j_reg),
        .mul_en     (rd_vld_reg),
        .acc_clr    (cmd.hist_write),
        .acc_en     (prod_vld_reg),
        .y          (y_q),
        .sat        (sat_q)
    );

    assign stat.clear_last = (clr_addr_reg == IDX_W'(MAX_TAPS - 1));
    assign stat.mac_last   = (k_reg == nreg_last);
    assign stat.pipe_busy  = rd_vld_reg | prod_vld_reg;
    assign stat.out_free   = out_free;

    assign result.valid    = out_valid_reg;
    assign result.out_i    = out_i_reg;
    assign result.out_q    = out_q_reg;
    assign result.clipped  = clipped_reg;
    assign result.last_out = last_out_reg;

endmodule

`default_nettype wire

// ===== rtl/dcf_checker.sv =====
// port-level checks on the filter handshakes, bound to the top level
`default_nettype none

module dcf_port_checker (
    input wire logic                     clk,
    input wire logic                     rst_n,
    input wire logic                     item_valid,
    input wire logic                     item_ready,
    input wire logic [dcf_pkg::OP_W-1:0] item_operation,
    input wire logic                     result_valid,
    input wire logic                     result_ready
);

    logic       sample_beat;
    logic       result_beat;
    logic [2:0] pending_reg;

    assign sample_beat = item_valid && item_ready && (item_operation == dcf_pkg::OP_SAMPLE);
    assign result_beat = result_valid && result_ready;

    // sample beats accepted but not yet delivered
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_reg + 3'(sample_beat) - 3'(result_beat);
        end
    end

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid)
        else $error("result dropped before it was taken");

    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> pending_reg != 3'd0)
        else $error("result shown with no sample beat outstanding");

    a_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg <= 3'd2)
        else $error("more sample beats in flight than the design can hold");

    a_busy_after: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready &&
        (item_operation == dcf_pkg::OP_SAMPLE || item_operation == dcf_pkg::OP_CLEAR)
        |=> !item_ready)
        else $error("input taken while a sample or clear is still running");

    a_sweep_after_reset: assert property (@(posedge clk)
        !$past(rst_n) |-> !item_ready)
        else $error("input taken before the history sweep");

endmodule

bind dual_channel_fir_filter dcf_port_checker u_dcf_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .item_valid     (item.valid),
    .item_ready     (item.ready),
    .item_operation (item.operation),
    .result_valid   (result.valid),
    .result_ready   (result.ready)
);

`default_nettype wire
